// ===== rtl/cms_pkg.sv =====
// Shared types and constants for the count-min sketch block.
package cms_pkg;

   localparam int KEY_W = 64;
   localparam int CNT_W = 31;
   localparam int EST_W = 30;
   localparam int NUM_SEEDS = 3;
   // counters per row; the hash index is the low bits of the row hash
   localparam int ROW_WIDTH = 65536;

   typedef enum logic [1:0] {
      ACT_MARK  = 2'd0,
      ACT_COUNT = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [1:0] CSR_SEED0 = 2'd0;
   localparam logic [1:0] CSR_SEED1 = 2'd1;
   localparam logic [1:0] CSR_SEED2 = 2'd2;

   localparam logic [KEY_W-1:0] SEED0_RESET = 64'h0000_0000_dead_beef;
   localparam logic [KEY_W-1:0] SEED1_RESET = 64'h0000_0000_cafe_babe;
   localparam logic [KEY_W-1:0] SEED2_RESET = 64'h0000_0000_1234_5678;

   localparam logic [CNT_W-1:0] CNT_MAX = 31'h7fff_ffff;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_WRITE,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/count_min_sketch_with_mark_top.sv =====
// Top level of the count-min sketch with mark bits.
//
// Usage:
//  - req_ channel: one item per transfer (req_action, req_key), taken when
//    req_valid is high and req_stall is low.
//  - rsp_ channel: exactly one result per item (rsp_all_marked,
//    rsp_estimate), taken when rsp_valid is high and rsp_stall is low.
//  - csr_ channel: seed writes (csr_index 0..2), taken when csr_valid and
//    csr_ready are high; other indexes are dropped. Write only while idle.
//  - Front end hashes a key row by row: 8 key bytes, each taking three
//    32x32 partial products, then one step to store the index.
//  - Back end walks each row through read, wait and write for count and
//    query and through write alone for mark, between idle and result states.
//  - The hash is the bottleneck; it takes no new key until the last is queued.
//  - After reset the counter memory is cleared, one entry per cycle over all
//    ROWS*ROW_WIDTH entries; items wait in the queue meanwhile.
//  - When the receiver stalls, the result holds and the back end halts;
//    the queue fills, then req_stall rises.
module count_min_sketch_with_mark_top #(
   parameter int ROWS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_all_marked,
   output logic [29:0] rsp_estimate,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import cms_pkg::*;

   localparam int IDX_W = $clog2(ROW_WIDTH);
   localparam int QW    = 2 + ROWS * IDX_W;

   logic [2:0][63:0]            seed_ff;
   logic                        hq_valid, hq_stall, q_valid, q_stall;
   logic [1:0]                  hq_action;
   logic [ROWS-1:0][IDX_W-1:0]  hq_index;
   logic [QW-1:0]               q_data;

   assign csr_ready = 1'b1;

   // hold seeds; drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff[0] <= SEED0_RESET;
         seed_ff[1] <= SEED1_RESET;
         seed_ff[2] <= SEED2_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SEED0: seed_ff[0] <= csr_wdata;
            CSR_SEED1: seed_ff[1] <= csr_wdata;
            CSR_SEED2: seed_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   cms_hash #(.ROWS(ROWS), .IDX_W(IDX_W)) u_hash (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_key,
      .seeds(seed_ff), .hq_valid, .hq_stall, .hq_action, .hq_index
   );

   cms_queue #(.W(QW)) u_queue (
      .clock, .reset,
      .in_valid(hq_valid), .in_stall(hq_stall), .in_data({hq_action, hq_index}),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   cms_exec #(.ROWS(ROWS), .IDX_W(IDX_W)) u_exec (
      .clock, .reset, .q_valid, .q_stall,
      .q_action(q_data[QW-1:QW-2]), .q_index(q_data[QW-3:0]),
      .rsp_valid, .rsp_stall, .rsp_all_marked, .rsp_estimate
   );

endmodule

// ===== rtl/cms_hash.sv =====
// Front end: iterative per-row hash of one key, one 32x32 partial product per cycle.
module cms_hash #(
   parameter int ROWS = 3,
   parameter int IDX_W = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [63:0]                     req_key,
   input  logic [2:0][63:0]                seeds,
   output logic                            hq_valid,
   input  logic                            hq_stall,
   output logic [1:0]                      hq_action,
   output logic [ROWS-1:0][IDX_W-1:0]      hq_index
);
   import cms_pkg::*;

   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic                          busy_ff, busy_in;
   logic [1:0]                    act_ff, act_in;
   logic [63:0]                   key_ff, key_in;
   logic [63:0]                   h_ff, h_in;
   logic [63:0]                   acc_ff, acc_in;
   logic [1:0]                    ph_ff, ph_in;
   logic [3:0]                    step_ff, step_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [ROWS-1:0][IDX_W-1:0]    idx_ff, idx_in;
   logic                          done_ff, done_in;
   // original key kept for restarting the byte walk on each row
   logic [63:0]                   keep_ff;
   logic [63:0]                   seed_cur;
   logic [7:0]                    byte_cur;
   logic [31:0]                   mul_a, mul_b;
   logic [63:0]                   prod;

   assign req_stall = busy_ff | done_ff;
   assign hq_valid  = done_ff;
   assign hq_action = act_ff;
   assign hq_index  = idx_ff;

   // h*s mod 2^64 = lo*lo + ((lo*hi + hi*lo) mod 2^32) << 32, one product per phase
   always_comb begin
      seed_cur = seeds[row_ff];
      byte_cur = key_ff[63:56];
      mul_a    = (ph_ff == 2'd2) ? h_ff[63:32] : h_ff[31:0];
      mul_b    = (ph_ff == 2'd1) ? seed_cur[63:32] : seed_cur[31:0];
      prod     = {32'd0, mul_a} * {32'd0, mul_b};
   end

   always_comb begin
      busy_in = busy_ff;
      act_in  = act_ff;
      key_in  = key_ff;
      h_in    = h_ff;
      acc_in  = acc_ff;
      ph_in   = ph_ff;
      step_in = step_ff;
      row_in  = row_ff;
      idx_in  = idx_ff;
      done_in = done_ff;
      if (done_ff && !hq_stall) begin
         done_in = 1'b0;
      end
      if (!busy_ff && !done_ff && req_valid) begin
         busy_in = 1'b1;
         act_in  = req_action;
         key_in  = req_key;
         h_in    = seeds[0];
         ph_in   = 2'd0;
         step_in = 4'd0;
         row_in  = '0;
      end else if (busy_ff) begin
         if (step_ff == 4'd8) begin
            idx_in[row_ff] = h_ff[IDX_W-1:0];
            ph_in = 2'd0;
            if (row_ff == ROW_W'(ROWS - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               row_in  = row_ff + 1'b1;
               h_in    = seeds[row_ff + 1'b1];
               step_in = 4'd0;
               key_in  = keep_ff;
            end
         end else begin
            case (ph_ff)
               2'd0: begin
                  acc_in = prod + {56'd0, byte_cur};
                  ph_in  = 2'd1;
               end
               2'd1: begin
                  acc_in[63:32] = acc_ff[63:32] + prod[31:0];
                  ph_in = 2'd2;
               end
               default: begin
                  h_in    = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
                  key_in  = {key_ff[55:0], 8'd0};
                  step_in = step_ff + 4'd1;
                  ph_in   = 2'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && !done_ff && req_valid) begin
         keep_ff <= req_key;
      end
      act_ff  <= act_in;
      key_ff  <= key_in;
      h_ff    <= h_in;
      acc_ff  <= acc_in;
      ph_ff   <= ph_in;
      step_ff <= step_in;
      row_ff  <= row_in;
      idx_ff  <= idx_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== rtl/cms_queue.sv =====
// Two-entry queue between the hash front end and the counter back end.
module cms_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_stall,
   output logic [W-1:0] out_data
);
   import cms_pkg::*;

   logic [1:0][W-1:0] mem_ff;
   logic              wp_ff, rp_ff;
   logic [1:0]        cnt_ff;
   logic              push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (cnt_ff <= 2'd2) else $error("queue count overflow");
      end
   end

endmodule

// ===== rtl/cms_exec.sv =====
// Back end: per-row count RMW, query read, mark write; reset clear sweep.
module cms_exec #(
   parameter int ROWS = 3,
   parameter int IDX_W = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_stall,
   input  logic [1:0]                   q_action,
   input  logic [ROWS-1:0][IDX_W-1:0]   q_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_all_marked,
   output logic [29:0]                  rsp_estimate
);
   import cms_pkg::*;

   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int DEPTH  = ROWS * (2 ** IDX_W);
   localparam int ADDR_W = $clog2(DEPTH);

   logic [CNT_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0] rd_ff;

   state_type        state_ff, state_in;
   logic [ADDR_W:0]  clr_ff, clr_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             acc_ff, acc_in;
   logic [CNT_W-1:0] min_ff, min_in;
   logic             out_mark_ff, out_mark_in;
   logic [29:0]      out_est_ff, out_est_in;
   logic [ADDR_W-1:0] addr;
   logic             we;
   logic [CNT_W-1:0] wdata;
   logic [CNT_W-1:0] bumped;
   logic [1:0]       act;

   assign act = q_action;
   assign addr = (state_ff == ST_CLEAR) ? clr_ff[ADDR_W-1:0]
               : ADDR_W'(row_ff * (2 ** IDX_W)) + ADDR_W'(q_index[row_ff]);
   assign bumped = (rd_ff[CNT_W-1:1] != CNT_MAX[CNT_W-1:1]) ?
                   rd_ff + CNT_W'(2) : rd_ff;

   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_all_marked = out_mark_ff;
   assign rsp_estimate   = out_est_ff;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      row_in      = row_ff;
      acc_in      = acc_ff;
      min_in      = min_ff;
      out_mark_in = out_mark_ff;
      out_est_in  = out_est_ff;
      we          = 1'b0;
      wdata       = '0;
      q_stall     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (ADDR_W+1)'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            row_in = '0;
            acc_in = 1'b1;
            min_in = CNT_MAX;
            if (q_valid) begin
               if (act == ACT_MARK) begin
                  state_in = ST_WRITE;
               end else if (act == ACT_NONE) begin
                  out_mark_in = 1'b0;
                  out_est_in  = '0;
                  state_in    = ST_OUT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_WRITE;
         ST_WRITE: begin
            if (act == ACT_MARK) begin
               we = 1'b1; wdata = CNT_W'(1);
            end else if (act == ACT_COUNT) begin
               we = 1'b1; wdata = bumped;
               acc_in = acc_ff & bumped[0];
            end else begin
               if (rd_ff < min_ff) min_in = rd_ff;
            end
            if (row_ff == ROW_W'(ROWS - 1)) begin
               out_mark_in = (act == ACT_COUNT) ? (acc_ff & bumped[0]) : 1'b0;
               out_est_in  = (act == ACT_QUERY) ?
                  ((rd_ff < min_ff) ? rd_ff[CNT_W-1:1] : min_ff[CNT_W-1:1]) : '0;
               state_in = ST_OUT;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = (act == ACT_MARK) ? ST_WRITE : ST_READ;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               q_stall  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      acc_ff      <= acc_in;
      min_ff      <= min_in;
      out_mark_ff <= out_mark_in;
      out_est_ff  <= out_est_in;
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   property p_out_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_estimate));
   endproperty
   assert property (p_out_hold) else $error("result dropped under stall");

   property p_pop_on_out;
      @(posedge clock) disable iff (reset)
         !q_stall |-> (state_ff == ST_OUT);
   endproperty
   assert property (p_pop_on_out) else $error("queue popped outside result");

   property p_mark_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_all_marked) |-> (rsp_estimate == '0);
   endproperty
   assert property (p_mark_zero) else $error("both result fields set");

endmodule

// ===== tb/count_min_sketch_with_mark_top_tb.sv =====
// Testbench for the count-min sketch with mark bits: directed and random items checked
// against a behavioral model.
module count_min_sketch_with_mark_top_tb;
   import cms_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = 3;
   // Memory clear after reset covers ROWS*ROW_WIDTH entries; leave ample room on top.
   localparam int STALL_LIMIT = 600000;
   // Settle beyond the end-to-end latency of one item.
   localparam int SETTLE_CYCLES = 100;
   localparam int POOL_SIZE = 16;

   typedef struct packed {
      logic        all_marked;
      logic [29:0] estimate;
   } sketch_result;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_MARK;
   logic [63:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_all_marked;
   logic [29:0] rsp_estimate;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SEED0;
   logic [63:0] csr_wdata = '0;

   // Model state: seeds and the counters that have been touched.
   logic [63:0]  seed_model [NUM_SEEDS];
   logic [30:0]  counter_model [int];
   sketch_result pending_results [$];
   logic [63:0]  key_pool [POOL_SIZE];

   int  mismatch_count = 0;
   bit  quiet = 1'b0;       // no random idling on either side while set
   bit  hold_go = 1'b0;     // ask the receiver for one long hold-off
   int  rsp_wait = 0;
   int  hold_left = 0;
   int  idle_cycles = 0;

   count_min_sketch_with_mark_top #(
      .ROWS(ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_all_marked(rsp_all_marked),
      .rsp_estimate(rsp_estimate),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Counter slot of one row: multiply-add hash over the key bytes, high byte first.
   function automatic int slot_of(int row, logic [63:0] key);
      logic [63:0] h;
      logic [63:0] s;
      s = seed_model[row];
      h = s;
      for (int b = 7; b >= 0; b--) begin
         h = h * s + {56'd0, key[b*8 +: 8]};
      end
      return row * ROW_WIDTH + int'(h % ROW_WIDTH);
   endfunction

   function automatic logic [30:0] counter_at(int slot);
      if (counter_model.exists(slot)) begin
         return counter_model[slot];
      end
      return '0;
   endfunction

   // Apply one item to the model counters and return the result it produces.
   function automatic sketch_result apply_sketch_item(logic [1:0] action, logic [63:0] key);
      sketch_result res;
      logic [30:0]  c;
      logic [30:0]  lowest;
      logic         all_odd;
      int           slot;
      res = '0;
      lowest = CNT_MAX;
      all_odd = 1'b1;
      for (int r = 0; r < ROWS; r++) begin
         slot = slot_of(r, key);
         c = counter_at(slot);
         case (action)
            ACT_MARK: begin
               counter_model[slot] = 31'd1;
            end
            ACT_COUNT: begin
               // count part saturates, mark bit is never touched
               if (c[30:1] != '1) begin
                  c = c + 31'd2;
               end
               counter_model[slot] = c;
               all_odd &= c[0];
            end
            ACT_QUERY: begin
               if (c < lowest) begin
                  lowest = c;
               end
            end
            default: ;
         endcase
      end
      if (action == ACT_COUNT) begin
         res.all_marked = all_odd;
      end
      if (action == ACT_QUERY) begin
         res.estimate = lowest[30:1];
      end
      return res;
   endfunction

   // Offer one item after a random gap; valid stays high on return.
   task automatic send_item(logic [1:0] action, logic [63:0] key);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_key <= key;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_sketch_item(action, key));
   endtask

   // Write one register; valid stays high for back-to-back writes.
   task automatic csr_write(logic [1:0] index, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (index <= CSR_SEED2) begin
         seed_model[index] = data;
      end
   endtask

   task automatic write_seeds(logic [63:0] s0, logic [63:0] s1, logic [63:0] s2);
      csr_write(CSR_SEED0, s0);
      csr_write(CSR_SEED1, s1);
      csr_write(CSR_SEED2, s2);
      // index 3 maps to no register and must be dropped
      csr_write(2'd3, {$urandom, $urandom});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every result, then let the pipeline go quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Mostly pool keys so that marks, counts and queries meet on the same counters.
   task automatic run_workload(int n);
      logic [63:0] key;
      logic [1:0]  action;
      int          pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         key = (pick < 80) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : random_key();
         pick = $urandom_range(0, 99);
         if (pick < 15) action = ACT_MARK;
         else if (pick < 60) action = ACT_COUNT;
         else if (pick < 95) action = ACT_QUERY;
         else action = ACT_NONE;
         send_item(action, key);
         if (i % 100 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
         end
      end
      quiet = 1'b0;
   endtask

   task automatic test_directed();
      send_item(ACT_QUERY, 64'd0);
      send_item(ACT_COUNT, 64'd0);
      send_item(ACT_QUERY, 64'd0);
      send_item(ACT_MARK, 64'd0);
      send_item(ACT_COUNT, 64'd0);
      send_item(ACT_COUNT, 64'd0);
      send_item(ACT_QUERY, 64'd0);
      send_item(ACT_MARK, '1);
      send_item(ACT_COUNT, '1);
      send_item(ACT_QUERY, '1);
      send_item(ACT_COUNT, 64'h0123_4567_89ab_cdef);
      send_item(ACT_QUERY, 64'h0123_4567_89ab_cdef);
      send_item(ACT_NONE, 64'd0);
      send_item(ACT_NONE, '1);
      send_item(ACT_QUERY, '1);
      send_item(ACT_MARK, 64'h8000_0000_0000_0000);
      send_item(ACT_COUNT, 64'h8000_0000_0000_0000);
      send_item(ACT_QUERY, 64'h0000_0000_0000_0001);
      drain();
   endtask

   task automatic test_seed_settings();
      write_seeds(64'd0, 64'd0, 64'd0);
      run_workload(40);
      drain();
      write_seeds('1, '1, '1);
      run_workload(40);
      drain();
      write_seeds(64'd1, 64'h8000_0000_0000_0000, 64'd2);
      run_workload(40);
      drain();
      write_seeds(random_key(), random_key(), random_key());
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 4; phase++) begin
         run_workload(380);
         drain();
         if (phase < 3) begin
            write_seeds(random_key(), random_key(), random_key());
         end
      end
   endtask

   // Hold the receiver off while items keep coming, so the input side backs up.
   task automatic test_backpressure();
      hold_go = 1'b1;
      quiet = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_item(ACT_COUNT + 2'($urandom_range(0, 1)), key_pool[i % POOL_SIZE]);
      end
      quiet = 1'b0;
      drain();
   endtask

   // Take results and compare them with the oldest expectation.
   always @(posedge clock) begin
      sketch_result want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result: all_marked=%0d estimate=%0d",
                           rsp_all_marked, rsp_estimate);
               end
            end else begin
               want = pending_results.pop_front();
               if (rsp_all_marked !== want.all_marked || rsp_estimate !== want.estimate) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result differs: all_marked exp %0d got %0d, estimate exp %0d got %0d",
                              want.all_marked, rsp_all_marked, want.estimate, rsp_estimate);
                  end
               end
            end
            rsp_wait = quiet ? 0 : $urandom_range(0, 19);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         if (hold_go) begin
            hold_go = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (rsp_wait != 0);
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("count_min_sketch_with_mark_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      seed_model[0] = SEED0_RESET;
      seed_model[1] = SEED1_RESET;
      seed_model[2] = SEED2_RESET;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = random_key();
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_seed_settings();
      test_backpressure();
      test_random();
      drain();
      if (mismatch_count == 0) begin
         $display("count_min_sketch_with_mark_top: match");
      end else begin
         $display("count_min_sketch_with_mark_top: mismatch");
      end
      $finish;
   end

endmodule
